### hdl/catmull_rom_path_player_top_assert.svh
// ---------------------------------------------------------------------------
// Catmull-Rom path player assertion macros
// Shared property templates for the path player's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef CATMULL_ROM_PATH_PLAYER_TOP_ASSERT_SVH
`define CATMULL_ROM_PATH_PLAYER_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/crp_pkg.sv
// ---------------------------------------------------------------------------
// Catmull-Rom path player package
// Beat types, opcodes, result kinds and fixed arithmetic widths.
// ---------------------------------------------------------------------------
package crp_pkg;

    // Fixed field widths.
    localparam int unsigned COORD_W = 24;
    localparam int unsigned NCOORD  = 9;
    localparam int unsigned TIME_W  = 21;
    localparam int unsigned DT_W    = 16;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned T_W     = FRAC_W + 1;

    // Spline datapath widths: the accumulator stays within 24 times a coordinate.
    localparam int unsigned SW = COORD_W + 5;
    localparam int unsigned PW = SW + T_W + 1;

    localparam logic [T_W-1:0]    T_ONE       = T_W'(1) << FRAC_W;
    localparam logic [TIME_W-1:0] TIME_MAX    = '1;
    localparam logic [TIME_W-1:0] LIMIT_RESET = TIME_W'(1310720);

    // Register word index of record_time_limit.
    localparam logic REG_RECORD_TIME_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_RECORD = 2'd1,
        OP_REMOVE = 2'd2,
        OP_START  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_INTERP  = 2'd1,
        KIND_RESTORE = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    typedef struct packed {
        t_opcode                   opcode;
        logic [DT_W-1:0]           delta_time;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] fwd_x;
        logic signed [COORD_W-1:0] fwd_y;
        logic signed [COORD_W-1:0] fwd_z;
        logic signed [COORD_W-1:0] up_x;
        logic signed [COORD_W-1:0] up_y;
        logic signed [COORD_W-1:0] up_z;
    } t_in_beat;

    typedef struct packed {
        t_kind                     result_kind;
        logic signed [COORD_W-1:0] out_pos_x;
        logic signed [COORD_W-1:0] out_pos_y;
        logic signed [COORD_W-1:0] out_pos_z;
        logic signed [COORD_W-1:0] out_fwd_x;
        logic signed [COORD_W-1:0] out_fwd_y;
        logic signed [COORD_W-1:0] out_fwd_z;
        logic signed [COORD_W-1:0] out_up_x;
        logic signed [COORD_W-1:0] out_up_y;
        logic signed [COORD_W-1:0] out_up_z;
        logic                      is_playing;
    } t_out_beat;

endpackage

### hdl/catmull_rom_path_player_top.sv
// ---------------------------------------------------------------------------
// Catmull-Rom path player
// Records key poses with gap times and replays them by spline interpolation.
// ---------------------------------------------------------------------------
// Each beat is handled one at a time. A playing tick reads the gap, runs a
// restoring divider for the 16-bit fraction t (skipped when t clamps to one),
// reads the four key-point rows one at a time from the point memory, and
// evaluates each of the nine coordinates in turn on the shared Horner
// multiplier. A new beat is taken while the previous result still waits in
// the output register.
module catmull_rom_path_player_top #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  crp_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output crp_pkg::t_out_beat o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import crp_pkg::*;

    localparam int unsigned IW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned RW = NCOORD * COORD_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GAP  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_EVAL = 7'b0010000,
        S_RMW  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // Key-point memories.
    logic [RW-1:0]     mem_row [MAX_POINTS];
    logic [TIME_W-1:0] mem_gap [MAX_POINTS];

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic                r_playing;
    logic [IW-1:0]       r_seg;
    logic [TIME_W-1:0]   r_elapsed;
    logic [TIME_W-1:0]   r_timer;
    logic [TIME_W-1:0]   r_limit;
    logic [DT_W-1:0]     r_dt;
    logic [TIME_W-1:0]   r_gap;
    logic [TIME_W-1:0]   r_rem;
    logic [FRAC_W-1:0]   r_q;
    logic [3:0]          r_div_cnt;
    logic [T_W-1:0]      r_t;
    logic [2:0]          r_rd_cnt;
    logic [3:0]          r_ci;
    logic                r_ev_start;
    logic [RW-1:0]       r_row [4];
    logic [RW-1:0]       row_rdata;
    logic [TIME_W-1:0]   gap_rdata;
    logic signed [COORD_W-1:0] r_pose [NCOORD];
    t_kind               r_kind;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic              in_acc;
    logic              cfg_wr;
    logic [RW-1:0]     in_row;
    logic              row_re;
    logic [IW-1:0]     row_raddr;
    logic              row_we;
    logic [IW-1:0]     last_idx;
    logic              gap_re;
    logic [IW-1:0]     gap_raddr;
    logic [TIME_W-1:0] rec_gap;
    logic [TIME_W:0]   timer_sum;
    logic [TIME_W:0]   elap_sum;
    logic [TIME_W-1:0] elap_sat;
    logic              seg_adv;
    logic [TIME_W-1:0] elap_new;
    logic [CW:0]       seg_new;
    logic [TIME_W:0]   rem_dbl;
    logic              div_bit;
    logic [FRAC_W-1:0] q_next;
    logic [CW:0]       k_ext;
    logic [IW-1:0]     i0, i3;
    logic              ev_done;
    logic signed [COORD_W-1:0] ev_result;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_RECORD_TIME_LIMIT) ? {11'd0, r_limit} : 32'd0;
    assign last_idx   = IW'(r_count - CW'(1));

    // Packed row of the incoming pose, coordinate 0 in the low bits.
    assign in_row = {i_in_data.up_z, i_in_data.up_y, i_in_data.up_x,
                     i_in_data.fwd_z, i_in_data.fwd_y, i_in_data.fwd_x,
                     i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};

    // Gap stored by a record: zero for the first point, else the clamped timer.
    always_comb begin
        if (r_count == '0) begin
            rec_gap = '0;
        end else if (r_timer >= r_limit) begin
            rec_gap = r_limit;
        end else begin
            rec_gap = r_timer;
        end
    end
    assign timer_sum = {1'b0, r_timer} + (TIME_W+1)'(i_in_data.delta_time);
    assign row_we    = in_acc && (i_in_data.opcode == OP_RECORD)
                       && (r_count < CW'(MAX_POINTS));

    // Elapsed time update against the segment gap.
    assign elap_sum = {1'b0, r_elapsed} + (TIME_W+1)'(r_dt);
    assign elap_sat = elap_sum[TIME_W] ? TIME_MAX : elap_sum[TIME_W-1:0];
    assign seg_adv  = (elap_sat >= gap_rdata);
    assign elap_new = seg_adv ? (elap_sat - gap_rdata) : elap_sat;
    assign seg_new  = (CW+1)'(r_seg) + (CW+1)'(seg_adv);
    assign rem_dbl  = {r_rem, 1'b0};
    assign div_bit  = (rem_dbl >= {1'b0, r_gap});
    assign q_next   = {r_q[FRAC_W-2:0], div_bit};

    // Outer control points, repeated at the ends of the path.
    assign k_ext = (CW+1)'(r_seg);
    assign i0    = (r_seg == '0) ? r_seg : r_seg - IW'(1);
    assign i3    = ((k_ext + (CW+1)'(3)) > (CW+1)'(r_count)) ? r_seg + IW'(1)
                                                            : r_seg + IW'(2);

    // Read port selection for the two memories.
    assign gap_re    = in_acc && (i_in_data.opcode == OP_TICK) && r_playing;
    assign gap_raddr = r_seg + IW'(1);
    always_comb begin
        row_re    = 1'b0;
        row_raddr = last_idx;
        if (r_state == S_IDLE) begin
            row_re = in_acc && (i_in_data.opcode == OP_REMOVE) && (r_count != '0);
        end else if (r_state == S_RD && r_rd_cnt != 3'd4) begin
            row_re = 1'b1;
            case (r_rd_cnt[1:0])
                2'd0:    row_raddr = i0;
                2'd1:    row_raddr = r_seg;
                2'd2:    row_raddr = r_seg + IW'(1);
                default: row_raddr = i3;
            endcase
        end
    end

    // Point and gap memories, one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            mem_row[IW'(r_count)] <= in_row;
            mem_gap[IW'(r_count)] <= rec_gap;
        end
        if (row_re) begin
            row_rdata <= mem_row[row_raddr];
        end
        if (gap_re) begin
            gap_rdata <= mem_gap[gap_raddr];
        end
    end

    // Shared coordinate evaluator.
    crp_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_ev_start),
        .i_p0     (r_row[0][r_ci*COORD_W +: COORD_W]),
        .i_p1     (r_row[1][r_ci*COORD_W +: COORD_W]),
        .i_p2     (r_row[2][r_ci*COORD_W +: COORD_W]),
        .i_p3     (r_row[3][r_ci*COORD_W +: COORD_W]),
        .i_t      (r_t),
        .o_done   (ev_done),
        .o_result (ev_result)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (cfg_wr && paddr[2] == REG_RECORD_TIME_LIMIT) begin
            r_limit <= pwdata[TIME_W-1:0];
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_playing   <= 1'b0;
            r_seg       <= '0;
            r_elapsed   <= '0;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
            r_ev_start  <= 1'b0;
        end else begin
            // Evaluator start pulses: after the row reads, and after each coordinate but the last.
            r_ev_start <= (r_state == S_RD && r_rd_cnt == 3'd4)
                          || (r_state == S_EVAL && ev_done && r_ci != 4'(NCOORD - 1));
            // Output beat: loaded from the done state, dropped once taken.
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dt <= i_in_data.delta_time;
                        for (int j = 0; j < NCOORD; j++) begin
                            r_pose[j] <= '0;
                        end
                        case (i_in_data.opcode)
                            OP_TICK: begin
                                r_kind <= KIND_NONE;
                                if (!r_playing) begin
                                    r_timer <= (timer_sum > {1'b0, r_limit}) ? r_limit
                                                                  : timer_sum[TIME_W-1:0];
                                    r_state <= S_DONE;
                                end else if (r_count < CW'(2)
                                             || (CW+1)'(r_seg) + (CW+1)'(1)
                                                >= (CW+1)'(r_count)) begin
                                    r_playing <= 1'b0;
                                    r_seg     <= '0;
                                    r_elapsed <= '0;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_state <= S_GAP;
                                end
                            end
                            OP_RECORD: begin
                                r_state <= S_DONE;
                                if (r_count >= CW'(MAX_POINTS)) begin
                                    r_kind <= KIND_REJECT;
                                end else begin
                                    r_kind  <= KIND_NONE;
                                    r_count <= r_count + CW'(1);
                                    r_timer <= '0;
                                end
                            end
                            OP_REMOVE: begin
                                if (r_count == '0) begin
                                    r_kind  <= KIND_REJECT;
                                    r_state <= S_DONE;
                                end else begin
                                    r_kind  <= KIND_NONE;
                                    r_count <= r_count - CW'(1);
                                    r_timer <= '0;
                                    r_state <= S_RMW;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                                if (r_playing || r_count < CW'(2)) begin
                                    r_kind <= KIND_REJECT;
                                end else begin
                                    r_kind    <= KIND_NONE;
                                    r_playing <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_GAP: begin
                    r_gap <= gap_rdata;
                    if (seg_new + (CW+1)'(2) > (CW+1)'(r_count)) begin
                        r_playing <= 1'b0;
                        r_seg     <= '0;
                        r_elapsed <= '0;
                        r_state   <= S_DONE;
                    end else begin
                        r_seg     <= seg_new[IW-1:0];
                        r_elapsed <= elap_new;
                        r_rd_cnt  <= 3'd0;
                        if (gap_rdata == '0 || elap_new >= gap_rdata) begin
                            r_t     <= T_ONE;
                            r_state <= S_RD;
                        end else begin
                            r_rem     <= elap_new;
                            r_q       <= '0;
                            r_div_cnt <= 4'd0;
                            r_state   <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle; the remainder stays below the gap.
                    if (div_bit) begin
                        r_rem <= TIME_W'(rem_dbl - {1'b0, r_gap});
                    end else begin
                        r_rem <= rem_dbl[TIME_W-1:0];
                    end
                    r_q       <= q_next;
                    r_div_cnt <= r_div_cnt + 4'd1;
                    if (r_div_cnt == 4'd15) begin
                        r_t     <= {1'b0, q_next};
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_rd_cnt != 3'd0) begin
                        r_row[r_rd_cnt[1:0] - 2'd1] <= row_rdata;
                    end
                    r_rd_cnt <= r_rd_cnt + 3'd1;
                    if (r_rd_cnt == 3'd4) begin
                        r_ci    <= 4'd0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (ev_done) begin
                        r_pose[r_ci] <= ev_result;
                        if (r_ci == 4'(NCOORD - 1)) begin
                            r_kind  <= KIND_INTERP;
                            r_state <= S_DONE;
                        end else begin
                            r_ci <= r_ci + 4'd1;
                        end
                    end
                end
                S_RMW: begin
                    for (int j = 0; j < NCOORD; j++) begin
                        r_pose[j] <= row_rdata[j*COORD_W +: COORD_W];
                    end
                    r_kind  <= KIND_RESTORE;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.result_kind <= r_kind;
                        r_out.out_pos_x   <= r_pose[0];
                        r_out.out_pos_y   <= r_pose[1];
                        r_out.out_pos_z   <= r_pose[2];
                        r_out.out_fwd_x   <= r_pose[3];
                        r_out.out_fwd_y   <= r_pose[4];
                        r_out.out_fwd_z   <= r_pose[5];
                        r_out.out_up_x    <= r_pose[6];
                        r_out.out_up_y    <= r_pose[7];
                        r_out.out_up_z    <= r_pose[8];
                        r_out.is_playing  <= r_playing;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "catmull_rom_path_player_top_assert.svh"

    // The stored point count never exceeds the memory depth.
    `CRP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_POINTS), "point count overflow")
    // An accepted beat always takes the block out of the idle state in the next cycle.
    `CRP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, !o_in_ready, "beat taken while busy")
    // The interpolation fraction never exceeds one.
    `CRP_ASSERT_NOW(a_t_bound, i_clk, i_rst_n, r_state == S_EVAL, r_t <= T_ONE, "fraction above one")

endmodule

### hdl/crp_eval.sv
// ---------------------------------------------------------------------------
// Catmull-Rom coordinate evaluator
// Evaluates one coordinate of the cubic by Horner steps on one multiplier.
// ---------------------------------------------------------------------------
module crp_eval (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [crp_pkg::COORD_W-1:0] i_p0,
    input  logic signed [crp_pkg::COORD_W-1:0] i_p1,
    input  logic signed [crp_pkg::COORD_W-1:0] i_p2,
    input  logic signed [crp_pkg::COORD_W-1:0] i_p3,
    input  logic [crp_pkg::T_W-1:0]            i_t,
    output logic                               o_done,
    output logic signed [crp_pkg::COORD_W-1:0] o_result
);
    import crp_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_MUL  = 3'b010,
        E_ACC  = 3'b100
    } t_ev_state;

    t_ev_state            r_state;
    logic [1:0]           r_step;
    logic signed [SW-1:0] r_s;
    logic signed [SW-1:0] r_b;
    logic signed [SW-1:0] r_c;
    logic signed [SW-1:0] r_d;
    logic signed [PW-1:0] r_prod;

    logic signed [SW-1:0] e0, e1, e2, e3;
    logic signed [SW-1:0] coef_a, coef_b, coef_c, coef_d;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] rnd_sh;
    logic signed [SW-1:0] term;
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] half;
    logic signed [COORD_W-1:0] sat_val;

    // Sign-extended control points and the cubic's coefficients.
    assign e0 = {{(SW-COORD_W){i_p0[COORD_W-1]}}, i_p0};
    assign e1 = {{(SW-COORD_W){i_p1[COORD_W-1]}}, i_p1};
    assign e2 = {{(SW-COORD_W){i_p2[COORD_W-1]}}, i_p2};
    assign e3 = {{(SW-COORD_W){i_p3[COORD_W-1]}}, i_p3};
    assign coef_a = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
    assign coef_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    assign coef_c = e2 - e0;
    assign coef_d = e1 <<< 1;

    // Round the product by 2^-16, half up, and add the next term.
    assign rnd    = r_prod + PW'(32768);
    assign rnd_sh = rnd >>> FRAC_W;
    always_comb begin
        case (r_step)
            2'd0:    term = r_b;
            2'd1:    term = r_c;
            default: term = r_d;
        endcase
    end
    assign acc  = rnd_sh[SW-1:0] + term;
    assign half = (acc + SW'(1)) >>> 1;

    // Saturate the halved sum to the coordinate range.
    always_comb begin
        if (half[SW-1:COORD_W-1] == '0 || half[SW-1:COORD_W-1] == '1) begin
            sat_val = half[COORD_W-1:0];
        end else if (half[SW-1]) begin
            sat_val = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    // Horner sequencer: multiply, then round and accumulate, three times.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_step  <= 2'd0;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == E_ACC) && (r_step == 2'd2);
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_s     <= coef_a;
                        r_b     <= coef_b;
                        r_c     <= coef_c;
                        r_d     <= coef_d;
                        r_step  <= 2'd0;
                        r_state <= E_MUL;
                    end
                end
                E_MUL: begin
                    r_prod  <= r_s * $signed({1'b0, i_t});
                    r_state <= E_ACC;
                end
                E_ACC: begin
                    r_s <= acc;
                    if (r_step == 2'd2) begin
                        o_result <= sat_val;
                        r_state  <= E_IDLE;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= E_MUL;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

endmodule
